/* design/mtrc_pkg.sv */
package mtrc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_ID        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ADDRESS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_ADDRESS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_READ_COILS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_READ_REGS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WRITE_COILS = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WRITE_REGS = 3'd6;

    // function codes
    localparam logic [7:0] FC_READ_COILS     = 8'h01;
    localparam logic [7:0] FC_READ_REGISTERS = 8'h03;
    localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS     = 8'h10;

    // header byte offsets
    localparam logic [15:0] POS_PROTO_HI = 16'd2;
    localparam logic [15:0] POS_PROTO_LO = 16'd3;
    localparam logic [15:0] POS_LEN_HI   = 16'd4;
    localparam logic [15:0] POS_LEN_LO   = 16'd5;
    localparam logic [15:0] POS_UNIT     = 16'd6;
    localparam logic [15:0] POS_FUNC     = 16'd7;
    localparam logic [15:0] POS_ADDR_HI  = 16'd8;
    localparam logic [15:0] POS_ADDR_LO  = 16'd9;
    localparam logic [15:0] POS_QTY_HI   = 16'd10;
    localparam logic [15:0] POS_QTY_LO   = 16'd11;
    localparam logic [15:0] POS_BCOUNT   = 16'd12;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam logic [15:0] MIN_FRAME    = 16'd12;
    localparam logic [15:0] MBAP_PREFIX  = 16'd6;
    localparam logic [15:0] WRITE_HEAD   = 16'd13;
    localparam logic [15:0] COIL_ROUND   = 16'd7;

    // status codes
    localparam logic [4:0] ST_OK          = 5'd0;
    localparam logic [4:0] ST_SHORT       = 5'd1;
    localparam logic [4:0] ST_PROTOCOL    = 5'd2;
    localparam logic [4:0] ST_LENGTH      = 5'd3;
    localparam logic [4:0] ST_UNIT        = 5'd4;
    localparam logic [4:0] ST_FUNCTION    = 5'd5;
    localparam logic [4:0] ST_ADDRESS     = 5'd6;
    localparam logic [4:0] ST_QTY_RC      = 5'd7;
    localparam logic [4:0] ST_QTY_RR      = 5'd8;
    localparam logic [4:0] ST_QTY_WC      = 5'd9;
    localparam logic [4:0] ST_QTY_WR      = 5'd10;
    localparam logic [4:0] ST_SPAN        = 5'd11;
    localparam logic [4:0] ST_SIZE_RC     = 5'd12;
    localparam logic [4:0] ST_SIZE_RR     = 5'd13;
    localparam logic [4:0] ST_SIZE_WC     = 5'd14;
    localparam logic [4:0] ST_BCOUNT_WC   = 5'd15;
    localparam logic [4:0] ST_SIZE_WR     = 5'd16;
    localparam logic [4:0] ST_BCOUNT_WR   = 5'd17;

    typedef struct packed {
        logic [7:0]  unit_id;
        logic [15:0] first_address;
        logic [15:0] last_address;
        logic [15:0] max_read_coils;
        logic [15:0] max_read_registers;
        logic [15:0] max_write_coils;
        logic [15:0] max_write_registers;
    } cfg_t;

    // one finished frame, as captured by the front end
    typedef struct packed {
        logic [15:0] size;
        logic [15:0] protocol_word;
        logic [15:0] length_word;
        logic [7:0]  unit_byte;
        logic [7:0]  function_byte;
        logic [15:0] address_word;
        logic [15:0] quantity_word;
        logic [7:0]  byte_count;
    } frame_t;

    // check results between the two back end stages
    typedef struct packed {
        logic        short_frame;
        logic        bad_protocol;
        logic        bad_length;
        logic        bad_unit;
        logic        bad_function;
        logic        bad_address;
        logic [4:0]  qty_code;
        logic        bad_span;
        logic [4:0]  size_code;
        logic [7:0]  function_byte;
        logic [15:0] address_word;
        logic [15:0] quantity_word;
    } checks_t;

endpackage

/* design/mtrc_front.sv */
module mtrc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic [7:0]      byte_data,
    input  logic            byte_last,
    input  logic            queue_full,
    output logic            byte_ready,
    output logic            push,
    output mtrc_pkg::frame_t push_data
);
    import mtrc_pkg::*;

    logic [15:0] pos_reg, pos_next;
    frame_t      cap_reg, cap_next, cap_upd;
    logic        beat;

    assign byte_ready = !queue_full;
    assign beat       = byte_valid && byte_ready;

    // merge the current byte into the captured header
    always_comb
    begin
        cap_upd = cap_reg;
        unique case (pos_reg)
            POS_PROTO_HI: cap_upd.protocol_word[15:8] = byte_data;
            POS_PROTO_LO: cap_upd.protocol_word[7:0]  = byte_data;
            POS_LEN_HI:   cap_upd.length_word[15:8]   = byte_data;
            POS_LEN_LO:   cap_upd.length_word[7:0]    = byte_data;
            POS_UNIT:     cap_upd.unit_byte           = byte_data;
            POS_FUNC:     cap_upd.function_byte       = byte_data;
            POS_ADDR_HI:  cap_upd.address_word[15:8]  = byte_data;
            POS_ADDR_LO:  cap_upd.address_word[7:0]   = byte_data;
            POS_QTY_HI:   cap_upd.quantity_word[15:8] = byte_data;
            POS_QTY_LO:   cap_upd.quantity_word[7:0]  = byte_data;
            POS_BCOUNT:   cap_upd.byte_count          = byte_data;
            default:      ;
        endcase
        // saturate the frame size
        cap_upd.size = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;
    end

    always_comb
    begin
        pos_next = pos_reg;
        cap_next = cap_reg;
        if (beat)
        begin
            if (byte_last)
            begin
                pos_next = '0;
                cap_next = '0;
            end
            else
            begin
                pos_next = cap_upd.size;
                cap_next = cap_upd;
            end
        end
    end

    assign push      = beat && byte_last;
    assign push_data = cap_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cap_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            cap_reg <= cap_next;
        end
    end

    // the stored size field tracks the byte counter between frames
    a_size_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg.size == pos_reg)
        else $error("captured size out of step with byte counter");

endmodule

/* design/mtrc_queue.sv */
module mtrc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mtrc_pkg::frame_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output mtrc_pkg::frame_t head
);
    import mtrc_pkg::*;

    frame_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("frame pushed into a full queue");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

/* design/mtrc_back.sv */
module mtrc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mtrc_pkg::cfg_t   cfg,
    input  logic             frame_valid,
    input  mtrc_pkg::frame_t frame,
    output logic             frame_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [4:0]       res_status,
    output logic [7:0]       res_function,
    output logic [15:0]      res_address,
    output logic [15:0]      res_quantity
);
    import mtrc_pkg::*;

    checks_t     chk_reg, chk_next;
    logic        chk_valid_reg;
    logic        out_valid_reg;
    logic [4:0]  status_reg, status_next;
    logic [7:0]  func_reg;
    logic [15:0] addr_reg, qty_reg;
    logic        a_ready, b_ready;
    logic        a_load;

    logic [15:0] qty_max;
    logic [16:0] span;
    logic [16:0] coil_sum;
    logic [13:0] coil_bytes;
    logic [16:0] reg_bytes;
    logic [16:0] coil_need;
    logic [17:0] reg_need;

    assign b_ready   = !out_valid_reg || res_ready;
    assign a_ready   = !chk_valid_reg || b_ready;
    assign frame_pop = frame_valid && a_ready;
    assign a_load    = frame_pop;

    // stage A: run every check in parallel
    always_comb
    begin
        qty_max    = '0;
        span       = {1'b0, frame.address_word} + {1'b0, frame.quantity_word};
        coil_sum   = {1'b0, frame.quantity_word} + {1'b0, COIL_ROUND};
        coil_bytes = coil_sum[16:3];
        reg_bytes  = {frame.quantity_word, 1'b0};
        coil_need  = {1'b0, WRITE_HEAD} + {3'b000, coil_bytes};
        reg_need   = {2'b00, WRITE_HEAD} + {1'b0, reg_bytes};

        chk_next.short_frame   = frame.size < MIN_FRAME;
        chk_next.bad_protocol  = frame.protocol_word != '0;
        chk_next.bad_length    = (frame.size - MBAP_PREFIX) != frame.length_word;
        chk_next.bad_unit      = frame.unit_byte != cfg.unit_id;
        chk_next.bad_address   = (frame.address_word < cfg.first_address) ||
                                 (frame.address_word > cfg.last_address);
        chk_next.bad_span      = span > {1'b0, cfg.last_address};
        chk_next.bad_function  = 1'b0;
        chk_next.qty_code      = ST_OK;
        chk_next.size_code     = ST_OK;
        chk_next.function_byte = frame.function_byte;
        chk_next.address_word  = frame.address_word;
        chk_next.quantity_word = frame.quantity_word;

        unique case (frame.function_byte)
            FC_READ_COILS:
            begin
                qty_max = cfg.max_read_coils;
                if (frame.quantity_word == '0 || frame.quantity_word > qty_max)
                    chk_next.qty_code = ST_QTY_RC;
                if (frame.size != MIN_FRAME)
                    chk_next.size_code = ST_SIZE_RC;
            end
            FC_READ_REGISTERS:
            begin
                qty_max = cfg.max_read_registers;
                if (frame.quantity_word == '0 || frame.quantity_word > qty_max)
                    chk_next.qty_code = ST_QTY_RR;
                if (frame.size != MIN_FRAME)
                    chk_next.size_code = ST_SIZE_RR;
            end
            FC_WRITE_COILS:
            begin
                qty_max = cfg.max_write_coils;
                if (frame.quantity_word == '0 || frame.quantity_word > qty_max)
                    chk_next.qty_code = ST_QTY_WC;
                if (coil_need != {1'b0, frame.size})
                    chk_next.size_code = ST_SIZE_WC;
                else if (coil_bytes != {6'd0, frame.byte_count})
                    chk_next.size_code = ST_BCOUNT_WC;
            end
            FC_WRITE_REGS:
            begin
                qty_max = cfg.max_write_registers;
                if (frame.quantity_word == '0 || frame.quantity_word > qty_max)
                    chk_next.qty_code = ST_QTY_WR;
                if (reg_need != {2'b00, frame.size})
                    chk_next.size_code = ST_SIZE_WR;
                else if (reg_bytes != {9'd0, frame.byte_count})
                    chk_next.size_code = ST_BCOUNT_WR;
            end
            default:
            begin
                chk_next.bad_function = 1'b1;
            end
        endcase
    end

    // stage B: first failing check wins
    always_comb
    begin
        if (chk_reg.short_frame)
            status_next = ST_SHORT;
        else if (chk_reg.bad_protocol)
            status_next = ST_PROTOCOL;
        else if (chk_reg.bad_length)
            status_next = ST_LENGTH;
        else if (chk_reg.bad_unit)
            status_next = ST_UNIT;
        else if (chk_reg.bad_function)
            status_next = ST_FUNCTION;
        else if (chk_reg.bad_address)
            status_next = ST_ADDRESS;
        else if (chk_reg.qty_code != ST_OK)
            status_next = chk_reg.qty_code;
        else if (chk_reg.bad_span)
            status_next = ST_SPAN;
        else
            status_next = chk_reg.size_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                chk_valid_reg <= frame_valid;
            if (b_ready)
                out_valid_reg <= chk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
            chk_reg <= chk_next;
        if (b_ready && chk_valid_reg)
        begin
            status_reg <= status_next;
            func_reg   <= chk_reg.function_byte;
            addr_reg   <= chk_reg.address_word;
            qty_reg    <= chk_reg.quantity_word;
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_status   = status_reg;
    assign res_function = func_reg;
    assign res_address  = addr_reg;
    assign res_quantity = qty_reg;

    a_chk_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid_reg && !b_ready) |=> (chk_valid_reg && $stable(chk_reg)))
        else $error("stage A lost its frame while stalled");

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pop |-> (!chk_valid_reg || b_ready))
        else $error("frame popped into an occupied stage");

    a_func_fail_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid_reg && chk_reg.bad_function) |->
        (chk_reg.qty_code == ST_OK && chk_reg.size_code == ST_OK))
        else $error("quantity or size code set for an unknown function");

endmodule

/* design/modbus_tcp_request_checker.sv */
// Modbus TCP request checker.
//
// s_* carries the request one byte per beat, s_tlast on the final byte of a
// frame. For every frame the m_* channel returns one result beat with the
// status of the first failing check, the function code, the start address
// and the quantity taken from the header. cfg_* writes the unit number,
// the address window and the per-function quantity limits; write only
// while no frame is in flight.
//
// Throughput: one byte per cycle on s_* while s_tready is high, and one result
// per cycle on m_* while m_tready is high, even for back-to-back single-byte
// frames. A result passes through the queue, the check stage and the output
// register on its way to m_*.
//
// When m_tready stays low, the output register, the check stage and the
// two-entry frame queue fill, and then s_tready drops for every byte until a
// frame leaves the queue.
// Reset clears the byte counter, captured header, queue and pipeline valids
// and loads the default configuration; cfg_ready is always high.
module modbus_tcp_request_checker (
    input  logic        clk,
    input  logic        rst_n,
    // request bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [4:0] status, [12:5] function_code,
                                   // [28:13] start_address, [44:29] quantity,
                                   // [47:45] zero
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mtrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mtrc_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        queue_full, queue_not_empty;
    logic        push, pop;
    frame_t      push_data, head;
    logic [4:0]  res_status;
    logic [7:0]  res_function;
    logic [15:0] res_address, res_quantity;

    assign cfg_ready = 1'b1;

    // decode one register write; indexes past the list drop the beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UNIT_ID:         cfg_next.unit_id             = cfg_data[7:0];
                REG_FIRST_ADDRESS:   cfg_next.first_address       = cfg_data;
                REG_LAST_ADDRESS:    cfg_next.last_address        = cfg_data;
                REG_MAX_READ_COILS:  cfg_next.max_read_coils      = cfg_data;
                REG_MAX_READ_REGS:   cfg_next.max_read_registers  = cfg_data;
                REG_MAX_WRITE_COILS: cfg_next.max_write_coils     = cfg_data;
                REG_MAX_WRITE_REGS:  cfg_next.max_write_registers = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_id             <= 8'd1;
            cfg_reg.first_address       <= 16'd0;
            cfg_reg.last_address        <= 16'hFFFF;
            cfg_reg.max_read_coils      <= 16'd2000;
            cfg_reg.max_read_registers  <= 16'd125;
            cfg_reg.max_write_coils     <= 16'd1968;
            cfg_reg.max_write_registers <= 16'd123;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: count bytes, capture header, push finished frames
    mtrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .byte_last  (s_tlast),
        .queue_full (queue_full),
        .byte_ready (s_tready),
        .push       (push),
        .push_data  (push_data)
    );

    // hold finished frames until the checker takes them
    mtrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // back end: evaluate checks, prioritize, drive the result beat
    mtrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .frame_valid  (queue_not_empty),
        .frame        (head),
        .frame_pop    (pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_status   (res_status),
        .res_function (res_function),
        .res_address  (res_address),
        .res_quantity (res_quantity)
    );

    assign m_tdata = {3'b000, res_quantity, res_address, res_function, res_status};

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:0] <= ST_BCOUNT_WR))
        else $error("status code beyond the defined set");

    a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !s_tready)
        else $error("bytes accepted while the frame queue is full");

    a_ok_means_known_function: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4:0] == ST_OK) |->
        (m_tdata[12:5] == FC_READ_COILS || m_tdata[12:5] == FC_READ_REGISTERS ||
         m_tdata[12:5] == FC_WRITE_COILS || m_tdata[12:5] == FC_WRITE_REGS))
        else $error("accepted request with an unsupported function");

endmodule

/* dv/modbus_tcp_request_checker_test.sv */
`timescale 1ns / 1ps

// Request bytes go in on s_*, one verdict beat per frame comes back on m_*.
// The bench keeps its own copy of the register file and of the captured
// header, judges every frame the same way the block must, and matches each
// verdict beat against the oldest pending one.
module modbus_tcp_request_checker_test;
    import mtrc_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
    localparam int IDLE_PERCENT = 34;
    localparam int RANDOM_BYTES = 1250;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int WC_QTY_CAP   = 2040;  // keeps random write frames short
    localparam int WR_QTY_CAP   = 150;

    typedef struct packed {
        logic [4:0]  status;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
    } verdict_t;

    // ways a random request gets broken
    typedef enum int {
        FLAW_NONE,
        FLAW_TRUNCATE,
        FLAW_PROTOCOL,
        FLAW_LENGTH,
        FLAW_UNIT,
        FLAW_FUNCTION,
        FLAW_ADDRESS,
        FLAW_QUANTITY,
        FLAW_SPAN,
        FLAW_SIZE,
        FLAW_BYTE_COUNT,
        FLAW_NOISE
    } flaw_t;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [47:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // high while neither side may idle
    logic steady = 1'b0;

    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;
    int unsigned bytes_sent   = 0;

    verdict_t   pending_verdicts[$];
    logic [7:0] req_bytes[$];

    // register file as the block should hold it
    cfg_t rules;

    // header as captured so far in the open frame
    logic [15:0] rx_size;
    logic [15:0] rx_protocol;
    logic [15:0] rx_length;
    logic [7:0]  rx_unit;
    logic [7:0]  rx_function;
    logic [15:0] rx_address;
    logic [15:0] rx_quantity;
    logic [7:0]  rx_byte_count;

    modbus_tcp_request_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the verdict side at random, except during steady stretches.
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Count cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Match each verdict beat against the oldest pending verdict.
    always @(posedge clk)
    begin : verdict_check
        verdict_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                $display("%0t: verdict beat with no frame pending, expected none, actual %h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("status", want.status, m_tdata[4:0]);
                check_field("function_code", want.function_code, m_tdata[12:5]);
                check_field("start_address", want.start_address, m_tdata[28:13]);
                check_field("quantity", want.quantity, m_tdata[44:29]);
            end
        end
    end

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void clear_capture();
        rx_size       = 16'd0;
        rx_protocol   = 16'd0;
        rx_length     = 16'd0;
        rx_unit       = 8'd0;
        rx_function   = 8'd0;
        rx_address    = 16'd0;
        rx_quantity   = 16'd0;
        rx_byte_count = 8'd0;
    endfunction

    // First failing check of the finished frame, in the block's fixed order.
    function automatic logic [4:0] judge_request();
        int unsigned size;
        int unsigned addr;
        int unsigned qty;
        int unsigned limit;
        int unsigned need;
        logic [4:0]  qty_status;
        size = {16'd0, rx_size};
        addr = {16'd0, rx_address};
        qty  = {16'd0, rx_quantity};
        if (size < MIN_FRAME)
            return ST_SHORT;
        if (rx_protocol != 16'd0)
            return ST_PROTOCOL;
        if (size - MBAP_PREFIX != rx_length)
            return ST_LENGTH;
        if (rx_unit != rules.unit_id)
            return ST_UNIT;
        case (rx_function)
            FC_READ_COILS:
            begin
                limit      = {16'd0, rules.max_read_coils};
                qty_status = ST_QTY_RC;
            end
            FC_READ_REGISTERS:
            begin
                limit      = {16'd0, rules.max_read_registers};
                qty_status = ST_QTY_RR;
            end
            FC_WRITE_COILS:
            begin
                limit      = {16'd0, rules.max_write_coils};
                qty_status = ST_QTY_WC;
            end
            FC_WRITE_REGS:
            begin
                limit      = {16'd0, rules.max_write_registers};
                qty_status = ST_QTY_WR;
            end
            default:
                return ST_FUNCTION;
        endcase
        if (addr < rules.first_address || addr > rules.last_address)
            return ST_ADDRESS;
        if (qty == 0 || qty > limit)
            return qty_status;
        // start plus quantity is formed wide, so it never wraps
        if (addr + qty > rules.last_address)
            return ST_SPAN;
        case (rx_function)
            FC_READ_COILS:
                return (size != MIN_FRAME) ? ST_SIZE_RC : ST_OK;
            FC_READ_REGISTERS:
                return (size != MIN_FRAME) ? ST_SIZE_RR : ST_OK;
            FC_WRITE_COILS:
            begin
                need = (qty + COIL_ROUND) / 8;
                if (WRITE_HEAD + need != size)
                    return ST_SIZE_WC;
                return (need != rx_byte_count) ? ST_BCOUNT_WC : ST_OK;
            end
            default:
            begin
                // twice the quantity stays at full width against an 8-bit field
                need = 2 * qty;
                if (WRITE_HEAD + need != size)
                    return ST_SIZE_WR;
                return (need != rx_byte_count) ? ST_BCOUNT_WR : ST_OK;
            end
        endcase
    endfunction

    // Capture one accepted byte; on the frame end queue its verdict and clear.
    function automatic void track_byte(input logic [7:0] value, input logic last);
        case (rx_size)
            POS_PROTO_HI: rx_protocol[15:8] = value;
            POS_PROTO_LO: rx_protocol[7:0]  = value;
            POS_LEN_HI:   rx_length[15:8]   = value;
            POS_LEN_LO:   rx_length[7:0]    = value;
            POS_UNIT:     rx_unit           = value;
            POS_FUNC:     rx_function       = value;
            POS_ADDR_HI:  rx_address[15:8]  = value;
            POS_ADDR_LO:  rx_address[7:0]   = value;
            POS_QTY_HI:   rx_quantity[15:8] = value;
            POS_QTY_LO:   rx_quantity[7:0]  = value;
            POS_BCOUNT:   rx_byte_count     = value;
            default:      ;
        endcase
        // the count saturates on very long frames
        if (rx_size != POS_MAX)
            rx_size = rx_size + 16'd1;
        if (last)
        begin
            pending_verdicts.push_back('{status:        judge_request(),
                                         function_code: rx_function,
                                         start_address: rx_address,
                                         quantity:      rx_quantity});
            clear_capture();
        end
    endfunction

    // Offer one byte beat, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] value, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        bytes_sent++;
        track_byte(value, last);
    endtask

    task automatic send_request();
        int unsigned count;
        count = req_bytes.size();
        for (int unsigned i = 0; i < count; i++)
            send_byte(req_bytes[i], i == count - 1);
    endtask

    // Drop the byte stream, let every verdict arrive, and let the pipe settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (index)
            REG_UNIT_ID:         rules.unit_id             = value[7:0];
            REG_FIRST_ADDRESS:   rules.first_address       = value;
            REG_LAST_ADDRESS:    rules.last_address        = value;
            REG_MAX_READ_COILS:  rules.max_read_coils      = value;
            REG_MAX_READ_REGS:   rules.max_read_registers  = value;
            REG_MAX_WRITE_COILS: rules.max_write_coils     = value;
            REG_MAX_WRITE_REGS:  rules.max_write_registers = value;
            default:             ;  // no such register, write is dropped
        endcase
    endtask

    task automatic write_all(input logic [15:0] unit, input logic [15:0] first,
                             input logic [15:0] last, input logic [15:0] rc,
                             input logic [15:0] rr, input logic [15:0] wc,
                             input logic [15:0] wr);
        wait_idle();
        write_reg(REG_UNIT_ID, unit);
        write_reg(REG_FIRST_ADDRESS, first);
        write_reg(REG_LAST_ADDRESS, last);
        write_reg(REG_MAX_READ_COILS, rc);
        write_reg(REG_MAX_READ_REGS, rr);
        write_reg(REG_MAX_WRITE_COILS, wc);
        write_reg(REG_MAX_WRITE_REGS, wr);
    endtask

    // Build a well-formed request into req_bytes, write data random.
    function automatic void build_request(input logic [7:0] fc, input logic [15:0] addr,
                                          input logic [15:0] qty, input logic [7:0] unit);
        int unsigned q;
        int unsigned payload;
        int unsigned total;
        logic [15:0] length_field;
        q = {16'd0, qty};
        case (fc)
            FC_WRITE_COILS: payload = (q + COIL_ROUND) / 8;
            FC_WRITE_REGS:  payload = 2 * q;
            default:        payload = 0;
        endcase
        if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)
            total = WRITE_HEAD + payload;
        else
            total = MIN_FRAME;
        length_field = 16'(total - MBAP_PREFIX);
        req_bytes.delete();
        req_bytes.push_back(random_byte());
        req_bytes.push_back(random_byte());
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'h00);
        req_bytes.push_back(length_field[15:8]);
        req_bytes.push_back(length_field[7:0]);
        req_bytes.push_back(unit);
        req_bytes.push_back(fc);
        req_bytes.push_back(addr[15:8]);
        req_bytes.push_back(addr[7:0]);
        req_bytes.push_back(qty[15:8]);
        req_bytes.push_back(qty[7:0]);
        if (total > MIN_FRAME)
        begin
            req_bytes.push_back(payload[7:0]);
            repeat (payload) req_bytes.push_back(random_byte());
        end
    endfunction

    // Make the length field agree with the frame as it now stands.
    function automatic void fix_length();
        int unsigned field;
        field = req_bytes.size() - MBAP_PREFIX;
        req_bytes[4] = field[15:8];
        req_bytes[5] = field[7:0];
    endfunction

    function automatic void set_word(input int unsigned offset, input logic [15:0] value);
        req_bytes[offset]     = value[15:8];
        req_bytes[offset + 1] = value[7:0];
    endfunction

    task automatic test_well_formed();
        build_request(FC_READ_COILS, 16'h0000, 16'd1, rules.unit_id);
        send_request();
        build_request(FC_READ_REGISTERS, 16'd65410, 16'd125, rules.unit_id);
        send_request();
        build_request(FC_WRITE_COILS, 16'h00FF, 16'd1968, rules.unit_id);
        send_request();
        build_request(FC_WRITE_REGS, 16'hFF00, 16'd123, rules.unit_id);
        send_request();
    endtask

    task automatic test_header_checks();
        // lone bytes, one frame each: short frames with nothing captured
        req_bytes = {8'hFF};
        send_request();
        req_bytes = {8'h00};
        send_request();
        // one byte short of a header: quantity low byte never arrives
        build_request(FC_READ_REGISTERS, 16'hA55A, 16'hFFFF, rules.unit_id);
        void'(req_bytes.pop_back());
        send_request();
        build_request(FC_READ_COILS, 16'd0, 16'd1, rules.unit_id);
        req_bytes[2] = 8'h80;
        send_request();
        build_request(FC_READ_COILS, 16'd0, 16'd1, rules.unit_id);
        req_bytes[3] = 8'h01;
        send_request();
        build_request(FC_READ_COILS, 16'd0, 16'd1, rules.unit_id);
        req_bytes[5] = req_bytes[5] ^ 8'h01;
        send_request();
        build_request(FC_READ_COILS, 16'd0, 16'd1, 8'd0);
        send_request();
        build_request(8'h00, 16'd0, 16'd1, rules.unit_id);
        send_request();
        build_request(8'hFF, 16'd0, 16'd1, rules.unit_id);
        send_request();
        build_request(8'h02, 16'd0, 16'd1, rules.unit_id);
        send_request();
        build_request(FC_READ_COILS, 16'd0, 16'd0, rules.unit_id);
        send_request();
        build_request(FC_READ_COILS, 16'd0, 16'd2001, rules.unit_id);
        send_request();
        build_request(FC_READ_REGISTERS, 16'd0, 16'd126, rules.unit_id);
        send_request();
        build_request(FC_WRITE_COILS, 16'd0, 16'd1969, rules.unit_id);
        send_request();
        build_request(FC_WRITE_REGS, 16'd0, 16'd124, rules.unit_id);
        send_request();
        build_request(FC_READ_COILS, 16'hFFFF, 16'd1, rules.unit_id);
        send_request();
    endtask

    task automatic test_size_checks();
        build_request(FC_READ_COILS, 16'd10, 16'd8, rules.unit_id);
        req_bytes.push_back(random_byte());
        fix_length();
        send_request();
        build_request(FC_READ_REGISTERS, 16'd10, 16'd8, rules.unit_id);
        req_bytes.push_back(random_byte());
        fix_length();
        send_request();
        build_request(FC_WRITE_COILS, 16'd10, 16'd9, rules.unit_id);
        req_bytes.push_back(random_byte());
        fix_length();
        send_request();
        build_request(FC_WRITE_COILS, 16'd10, 16'd9, rules.unit_id);
        req_bytes[12] = 8'd3;
        send_request();
        build_request(FC_WRITE_REGS, 16'd10, 16'd4, rules.unit_id);
        void'(req_bytes.pop_back());
        fix_length();
        send_request();
        build_request(FC_WRITE_REGS, 16'd10, 16'd4, rules.unit_id);
        req_bytes[12] = 8'd9;
        send_request();
    endtask

    task automatic test_register_extremes();
        // widest limits, unit at its top
        write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        build_request(FC_READ_COILS, 16'd0, 16'hFFFF, rules.unit_id);
        send_request();
        build_request(FC_READ_REGISTERS, 16'd0, 16'hFFFF, rules.unit_id);
        send_request();
        build_request(FC_WRITE_COILS, 16'd0, 16'd2040, rules.unit_id);
        send_request();
        build_request(FC_WRITE_COILS, 16'd0, 16'd2041, rules.unit_id);
        send_request();
        // 256 data bytes: the byte count field reads zero and must not match
        build_request(FC_WRITE_REGS, 16'd0, 16'd128, rules.unit_id);
        send_request();

        // narrowest limits, window pinned at the top address
        write_all(16'h0000, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1);
        build_request(FC_READ_COILS, 16'hFFFF, 16'd1, rules.unit_id);
        send_request();
        build_request(FC_READ_REGISTERS, 16'hFFFE, 16'd1, rules.unit_id);
        send_request();
        build_request(FC_WRITE_REGS, 16'hFFFF, 16'd2, rules.unit_id);
        send_request();
        build_request(FC_WRITE_COILS, 16'hFFFF, 16'd1, rules.unit_id);
        send_request();

        // window pinned at address zero
        wait_idle();
        write_reg(REG_FIRST_ADDRESS, 16'd0);
        write_reg(REG_LAST_ADDRESS, 16'd0);
        build_request(FC_READ_REGISTERS, 16'd0, 16'd1, rules.unit_id);
        send_request();
        build_request(FC_READ_COILS, 16'd1, 16'd1, rules.unit_id);
        send_request();

        // a write past the register file changes nothing
        wait_idle();
        write_reg(REG_UNUSED, 16'hFFFF);
        build_request(FC_READ_COILS, 16'd0, 16'd1, rules.unit_id);
        send_request();

        // empty window: every start address fails
        wait_idle();
        write_reg(REG_FIRST_ADDRESS, 16'd200);
        write_reg(REG_LAST_ADDRESS, 16'd100);
        build_request(FC_READ_REGISTERS, 16'd150, 16'd1, rules.unit_id);
        send_request();

        write_all(16'd1, 16'd0, 16'hFFFF, 16'd2000, 16'd125, 16'd1968, 16'd123);
    endtask

    // Run one frame past 65535 bytes so the byte count saturates. With the
    // count saturated the size matches 13 plus twice the quantity and only the
    // byte count field disagrees.
    task automatic test_long_frame();
        wait_idle();
        write_reg(REG_MAX_WRITE_REGS, 16'hFFFF);
        steady <= 1'b1;
        build_request(FC_WRITE_REGS, 16'd0, 16'd32761, rules.unit_id);
        repeat (5) req_bytes.push_back(random_byte());
        send_request();
        steady <= 1'b0;
        req_bytes.delete();
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 65535));
            default: return 16'($urandom_range(1, 400));
        endcase
    endfunction

    task automatic shuffle_config();
        logic [15:0] first;
        logic [15:0] last;
        case ($urandom_range(0, 5))
            0:
            begin
                first = 16'd0;
                last  = 16'hFFFF;
            end
            1:
            begin
                first = 16'($urandom_range(0, 65535));
                last  = first;
            end
            2:
            begin
                first = 16'($urandom_range(1, 65535));
                last  = 16'($urandom_range(0, first - 1));
            end
            default:
            begin
                first = 16'($urandom_range(0, 60000));
                last  = 16'($urandom_range(first, 65535));
            end
        endcase
        write_all(16'($urandom_range(0, 65535)), first, last, pick_limit(), pick_limit(),
                  pick_limit(), pick_limit());
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    endtask

    // Mostly well-formed requests under the current rules, some broken on
    // purpose, some pure noise.
    function automatic void make_random_request();
        flaw_t       flaw;
        logic [7:0]  fc;
        int unsigned rule_limit;
        int unsigned lim;
        int unsigned q;
        int unsigned lo;
        int unsigned hi;
        int unsigned addr;
        int unsigned n;
        if ($urandom_range(0, 99) < 60)
            flaw = FLAW_NONE;
        else
            flaw = flaw_t'($urandom_range(FLAW_TRUNCATE, FLAW_NOISE));
        case ($urandom_range(0, 3))
            0:
            begin
                fc         = FC_READ_COILS;
                rule_limit = {16'd0, rules.max_read_coils};
                lim        = rule_limit;
            end
            1:
            begin
                fc         = FC_READ_REGISTERS;
                rule_limit = {16'd0, rules.max_read_registers};
                lim        = rule_limit;
            end
            2:
            begin
                fc         = FC_WRITE_COILS;
                rule_limit = {16'd0, rules.max_write_coils};
                lim        = (rule_limit > WC_QTY_CAP) ? WC_QTY_CAP : rule_limit;
            end
            default:
            begin
                fc         = FC_WRITE_REGS;
                rule_limit = {16'd0, rules.max_write_registers};
                lim        = (rule_limit > WR_QTY_CAP) ? WR_QTY_CAP : rule_limit;
            end
        endcase
        if (lim == 0)
            lim = 1;
        if ($urandom_range(0, 4) == 0)
            q = lim;
        else
            q = $urandom_range(1, (lim < 16) ? lim : 16);
        lo = {16'd0, rules.first_address};
        hi = {16'd0, rules.last_address};
        if (hi >= lo + q)
            addr = $urandom_range(lo, hi - q);
        else if (hi >= lo)
            addr = $urandom_range(lo, hi);
        else
            addr = $urandom_range(0, 65535);
        build_request(fc, 16'(addr), 16'(q), rules.unit_id);

        case (flaw)
            FLAW_TRUNCATE:
            begin
                n = $urandom_range(1, 11);
                while (req_bytes.size() > n)
                    void'(req_bytes.pop_back());
            end
            FLAW_PROTOCOL:
                req_bytes[2 + $urandom_range(0, 1)] = 8'd1 << $urandom_range(0, 7);
            FLAW_LENGTH:
            begin
                n = 4 + $urandom_range(0, 1);
                req_bytes[n] = req_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
            end
            FLAW_UNIT:
                req_bytes[6] = req_bytes[6] ^ (8'd1 << $urandom_range(0, 7));
            FLAW_FUNCTION:
                req_bytes[7] = random_byte();
            FLAW_ADDRESS:
            begin
                if (lo > 0 && ($urandom_range(0, 1) == 0 || hi == 65535))
                    set_word(8, 16'($urandom_range(0, lo - 1)));
                else if (hi < 65535)
                    set_word(8, 16'($urandom_range(hi + 1, 65535)));
            end
            FLAW_QUANTITY:
            begin
                if (rule_limit < 65535 && $urandom_range(0, 1) == 0)
                    set_word(10, 16'(rule_limit + 1));
                else
                    set_word(10, 16'd0);
            end
            FLAW_SPAN:
            begin
                if (hi >= lo)
                    set_word(8, 16'(hi - $urandom_range(0, (q > 1) ? q - 1 : 0)));
            end
            FLAW_SIZE:
            begin
                if ($urandom_range(0, 1) == 0)
                    req_bytes.push_back(random_byte());
                else
                    void'(req_bytes.pop_back());
                if ($urandom_range(0, 3) != 0)
                    fix_length();
            end
            FLAW_BYTE_COUNT:
            begin
                if (req_bytes.size() > MIN_FRAME)
                    req_bytes[12] = req_bytes[12] ^ (8'd1 << $urandom_range(0, 7));
            end
            FLAW_NOISE:
            begin
                req_bytes.delete();
                repeat ($urandom_range(1, 24)) req_bytes.push_back(random_byte());
            end
            default:
                ;
        endcase
    endfunction

    task automatic test_random_traffic();
        int unsigned start_bytes;
        int unsigned frames;
        start_bytes = bytes_sent;
        frames      = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            if (frames % 16 == 0)
                shuffle_config();
            // hold both sides busy for a stretch in the middle
            if (frames == 40)
                steady <= 1'b1;
            if (frames == 60)
                steady <= 1'b0;
            make_random_request();
            send_request();
            frames++;
        end
    endtask

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rules.unit_id             = 8'd1;
        rules.first_address       = 16'd0;
        rules.last_address        = 16'hFFFF;
        rules.max_read_coils      = 16'd2000;
        rules.max_read_registers  = 16'd125;
        rules.max_write_coils     = 16'd1968;
        rules.max_write_registers = 16'd123;
        clear_capture();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed();
        test_header_checks();
        test_size_checks();
        test_register_extremes();
        test_long_frame();
        test_random_traffic();

        // drain, then watch for stray verdict beats
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
